[rtl/assert_macros.svh]
// assertion macros shared by the graph store rtl
// uses the clk_i and rst_ni names of the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AMGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define AMGS_ASSERT_NEVER(lbl, cond, msg) \
  `AMGS_ASSERT(lbl, !(cond), msg)
`else
`define AMGS_ASSERT(lbl, prop, msg)
`define AMGS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/amgs_pkg.sv]
// constants, opcodes and shared types of the adjacency matrix graph store
// no dependencies
package amgs_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned VtxW        = 6;
  localparam int unsigned OpW         = 3;
  localparam int unsigned RowW        = MaxVertices;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CountW      = VtxW + 1;
  localparam int unsigned Chunks      = (MaxVertices + 7) / 8;
  localparam int unsigned DegW        = $clog2(MaxVertices + 1);

  localparam logic [VtxW-1:0] VcountReset = VtxW'(32);

  typedef enum logic [OpW-1:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD_EDGE  = 3'd1,
    OP_ADJACENT  = 3'd2,
    OP_DEGREE    = 3'd3,
    OP_NEIGHBORS = 3'd4
  } op_e;

  typedef struct packed {
    logic             clr;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [RowW-1:0]  wr_row;
  } mem_req_t;

  typedef struct packed {
    logic [VtxW-1:0] value;
    logic            error;
    logic            last;
  } res_t;

endpackage

[rtl/amgs_if.sv]
// valid/ready channel interfaces of the graph store: operations, results, config
// depends on amgs_pkg
interface amgs_op_if import amgs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  logic [VtxW-1:0] vertex_a;
  logic [VtxW-1:0] vertex_b;

  modport source (output valid, output opcode, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input opcode, input vertex_a, input vertex_b, output ready);
endinterface

interface amgs_res_if import amgs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VtxW-1:0] value;
  logic            error;
  logic            last;

  modport source (output valid, output value, output error, output last, input ready);
  modport sink   (input valid, input value, input error, input last, output ready);
endinterface

interface amgs_cfg_if import amgs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VtxW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/amgs_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module amgs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/amgs_row_store.sv]
// adjacency row memory with per-row valid bits so reset and clear read as zero
// depends on amgs_pkg and amgs_ram
module amgs_row_store import amgs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mem_req_t        req_i,
  output logic [RowW-1:0] row_o
);

  logic [MaxVertices-1:0] valid_q;
  logic                   rd_valid_q;
  logic [RowW-1:0]        ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  amgs_ram #(
    .Width (RowW),
    .Depth (MaxVertices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_row),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  assign row_o = rd_valid_q ? ram_rdata : '0;

endmodule

[rtl/amgs_ctrl.sv]
// operation sequencer: decodes each operation, reads/modifies/writes rows, forms results
// depends on amgs_pkg, amgs_if and assert_macros.svh
`include "assert_macros.svh"
module amgs_ctrl import amgs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  amgs_cfg_if.sink        cfg_i,
  amgs_op_if.sink         op_i,
  output mem_req_t        mem_req_o,
  input  logic [RowW-1:0] row_i,
  input  logic            slot_free_i,
  output logic            push_o,
  output res_t            res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_A,
    S_ADD_B,
    S_READ,
    S_SUM,
    S_LIST,
    S_RESP
  } state_e;

  function automatic logic in_range(input logic [VtxW-1:0] v, input logic [CountW-1:0] n);
    return (v != '0) && ({1'b0, v} <= n);
  endfunction

  function automatic logic [RowW-1:0] low_mask(input logic [CountW-1:0] n);
    logic [RowW-1:0] m;
    for (int i = 0; i < RowW; i++) begin
      m[i] = (CountW'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [RowW-1:0] one_hot(input logic [AddrW-1:0] idx);
    return {{(RowW-1){1'b0}}, 1'b1} << idx;
  endfunction

  function automatic logic [AddrW-1:0] lowest_set(input logic [RowW-1:0] r);
    logic [AddrW-1:0] idx;
    idx = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (r[i]) begin
        idx = AddrW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [VtxW-1:0]   vcount_q;
  logic [VtxW-1:0]   a_q, b_q;
  res_t              res_q, res_d;
  logic [RowW-1:0]   list_q, list_d;
  logic [3:0]        cnt_q [Chunks];
  logic [3:0]        cnt_d [Chunks];

  logic                  accept;
  logic [OpW-1:0]        in_op;
  logic                  in_err;
  logic [AddrW-1:0]      in_a_idx;
  logic [AddrW-1:0]      a_idx, b_idx;
  logic [CountW-1:0]     n_eff;
  logic [RowW-1:0]       row_masked;
  logic [Chunks*8-1:0]   row_pad;
  logic [DegW-1:0]       deg_sum;
  logic [AddrW-1:0]      lst_idx;
  logic [RowW-1:0]       lst_rest;
  logic [VtxW-1:0]       lst_value;

  assign accept   = op_i.valid && op_i.ready;
  assign in_op    = op_i.opcode;
  assign n_eff    = ({1'b0, vcount_q} > CountW'(MaxVertices)) ? CountW'(MaxVertices)
                                                              : {1'b0, vcount_q};
  assign in_err   = !in_range(op_i.vertex_a, n_eff) ||
                    (((in_op == OP_ADD_EDGE) || (in_op == OP_ADJACENT)) &&
                     !in_range(op_i.vertex_b, n_eff));
  assign in_a_idx = AddrW'(op_i.vertex_a - VtxW'(1));
  assign a_idx    = AddrW'(a_q - VtxW'(1));
  assign b_idx    = AddrW'(b_q - VtxW'(1));

  assign row_masked = row_i & low_mask(n_eff);
  assign row_pad    = (Chunks*8)'(row_masked);

  assign lst_idx   = lowest_set(list_q);
  assign lst_rest  = list_q & ~one_hot(lst_idx);
  assign lst_value = VtxW'(lst_idx) + VtxW'(1);

  always_comb begin
    deg_sum = '0;
    for (int k = 0; k < Chunks; k++) begin
      deg_sum = deg_sum + DegW'(cnt_q[k]);
    end
  end

  assign cfg_i.ready = 1'b1;
  assign op_i.ready  = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    res_d     = res_q;
    list_d    = list_q;
    cnt_d     = cnt_q;
    mem_req_o = '0;
    push_o    = 1'b0;
    res_o     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_CLEAR) begin
            mem_req_o.clr = 1'b1;
            res_d         = '{value: '0, error: 1'b0, last: 1'b1};
            state_d       = S_RESP;
          end else if (in_op <= OP_NEIGHBORS) begin
            op_d = op_e'(in_op);
            if (in_err) begin
              res_d   = '{value: '0, error: 1'b1, last: 1'b1};
              state_d = S_RESP;
            end else begin
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = in_a_idx;
              state_d           = (in_op == OP_ADD_EDGE) ? S_ADD_A : S_READ;
            end
          end
        end
      end
      // both rows of a self-loop get the same value, so the stale second read is harmless
      S_ADD_A: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = a_idx;
        mem_req_o.wr_row  = row_i | one_hot(b_idx);
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = b_idx;
        state_d           = S_ADD_B;
      end
      S_ADD_B: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = b_idx;
        mem_req_o.wr_row  = row_i | one_hot(a_idx);
        res_d             = '{value: '0, error: 1'b0, last: 1'b1};
        state_d           = S_RESP;
      end
      S_READ: begin
        case (op_q)
          OP_ADJACENT: begin
            res_d   = '{value: VtxW'(row_masked[b_idx]), error: 1'b0, last: 1'b1};
            state_d = S_RESP;
          end
          OP_DEGREE: begin
            for (int k = 0; k < Chunks; k++) begin
              cnt_d[k] = pop8(row_pad[k*8 +: 8]);
            end
            state_d = S_SUM;
          end
          default: begin
            list_d  = row_masked;
            state_d = S_LIST;
          end
        endcase
      end
      S_SUM: begin
        res_d   = '{value: VtxW'(deg_sum), error: 1'b0, last: 1'b1};
        state_d = S_RESP;
      end
      S_LIST: begin
        push_o = slot_free_i;
        if (list_q == '0) begin
          res_o = '{value: '0, error: 1'b0, last: 1'b1};
        end else begin
          res_o = '{value: lst_value, error: 1'b0, last: (lst_rest == '0)};
        end
        if (slot_free_i) begin
          list_d = lst_rest;
          if ((list_q == '0) || (lst_rest == '0)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        push_o = slot_free_i;
        res_o  = res_q;
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vcount_q <= VcountReset;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        vcount_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    res_q  <= res_d;
    list_q <= list_d;
    cnt_q  <= cnt_d;
    if (accept) begin
      a_q <= op_i.vertex_a;
      b_q <= op_i.vertex_b;
    end
  end

  `AMGS_ASSERT(a_row_read_first, (state_q == S_ADD_A || state_q == S_ADD_B || state_q == S_READ) |-> $past(mem_req_o.rd_en), "row consumed without a read in the previous cycle")
  `AMGS_ASSERT(a_write_read_row, mem_req_o.wr_en |-> (mem_req_o.wr_addr == $past(mem_req_o.rd_addr)), "row written back to a different address than read")
  `AMGS_ASSERT(a_list_continues, (push_o && !res_o.last) |=> (state_q == S_LIST), "neighbor listing ended without a last result")
  `AMGS_ASSERT_NEVER(a_empty_list_late, state_q == S_LIST && list_q == '0 && $past(state_q) == S_LIST && $past(list_q) != '0, "empty list marker after neighbors were sent")

endmodule

[rtl/amgs_out_stage.sv]
// result output register between the sequencer and the result channel
// depends on amgs_pkg and amgs_if
module amgs_out_stage import amgs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_t      res_i,
  output logic      slot_free_o,
  amgs_res_if.source res_o
);

  logic valid_q;
  res_t data_q;

  assign slot_free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.value = data_q.value;
  assign res_o.error = data_q.error;
  assign res_o.last  = data_q.last;

endmodule

[rtl/adjacency_matrix_graph_store.sv]
// top level of the undirected graph store kept as an adjacency bit matrix
// depends on amgs_pkg, amgs_if, amgs_row_store, amgs_ctrl and amgs_out_stage
//
// cfg_i sets vertex_count and is always ready; write it only while no operation
// is in flight. op_i takes one operation (clear, add edge, adjacent query,
// degree, neighbor listing) while the sequencer is idle; res_o gives the
// results, with last set on the final result of each operation.
// Rows live in a one-port-read, one-port-write ram with registered read data;
// per-row valid bits make reset and clear take effect at once, no clearing pass.
// Steps of each operation after accept, in order:
//   clear, out-of-range vertex: result; adjacent query: read row, result
//   add edge: two read-modify-write passes, result; degree: read row, byte
//   popcounts, sum, result; neighbor listing: read row, then one result per
//   neighbor (one if none), one result per cycle while res_o is not stalled
// Undefined opcodes are dropped with no result. Results leave through the
// output register; a stalled res_o holds it, the sequencer waits on it and
// op_i stays not ready. After reset all rows read zero and vertex_count is 32.
module adjacency_matrix_graph_store import amgs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  amgs_cfg_if.sink   cfg_i,
  amgs_op_if.sink    op_i,
  amgs_res_if.source res_o
);

  mem_req_t        mem_req;
  logic [RowW-1:0] row;
  logic            slot_free;
  logic            push;
  res_t            res;

  amgs_row_store u_row_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .row_o  (row)
  );

  amgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .op_i        (op_i),
    .mem_req_o   (mem_req),
    .row_i       (row),
    .slot_free_i (slot_free),
    .push_o      (push),
    .res_o       (res)
  );

  amgs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .slot_free_o (slot_free),
    .res_o       (res_o)
  );

endmodule
